### src/u8d_pkg.sv
`timescale 1ns / 1ps
// u8d_pkg: shared types, status codes and helpers for the utf-8 decoder
// no dependencies

package u8d_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned MaxSeqLen     = 6;
  localparam logic [7:0]  ContMark      = 8'h80;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_WIDE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       flush;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_point;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  // all results caused by one input word
  typedef struct packed {
    logic      two;
    out_word_t r0;
    out_word_t r1;
  } rec_t;

  // queue to back end handshake
  typedef struct packed {
    logic avail;
    rec_t head;
  } q_head_t;

  function automatic logic [3:0] leading_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      if (run) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic out_word_t mk_res(input logic [15:0] cp, input status_e st);
    out_word_t r;
    r.code_point = cp;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

### src/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// utf8_byte_stream_decoder: top level of the utf-8 to 16-bit code point decoder
// depends on u8d_pkg, u8d_front, u8d_queue, u8d_back

// The decoder takes one byte word per clock whenever full is low and
// delivers one result word per clock whenever empty is low and pop is
// high. The front end decodes a byte in the cycle it is accepted and writes
// all results it causes (one or two) as one record into a queue of
// QueueDepth records; a byte that causes no result uses no queue slot. The
// back end reads the head record and returns its words in order, so a byte
// that both truncates a sequence and yields a result of its own needs two
// pops. Records are registered in the queue. Sustained rate is one byte
// per clock while no byte yields two results and the consumer drains one
// result per clock; full rises only when QueueDepth records are waiting.

module utf8_byte_stream_decoder import u8d_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input side
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  logic    accept;
  logic    rec_push;
  rec_t    rec;
  logic    deq;
  q_head_t head;

  // a byte word is taken whenever the queue can hold its record
  assign accept = push && !full;

  // decode and sequence state
  u8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .rec_push_o (rec_push),
    .rec_o      (rec)
  );

  // record queue decouples decoding from result delivery
  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .rec_i  (rec),
    .deq_i  (deq),
    .full_o (full),
    .head_o (head)
  );

  // splits each record into its result words
  u8d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_i      (pop),
    .deq_o      (deq),
    .empty_o    (empty),
    .out_word_o (out_word_o)
  );

  // error results never carry a code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status != ST_OK) |-> (out_word_o.code_point == 16'd0))
    else $error("error result with nonzero code point");

  // a popped word that is not last is followed by its partner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_word_o.last) |=> (!empty && out_word_o.last))
    else $error("second result of a byte missing");

  // the queue cannot drain without a completed record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !(pop && !empty)) |=> full)
    else $error("queue lost a record");

endmodule

### src/u8d_front.sv
`timescale 1ns / 1ps
// u8d_front: accepts bytes, tracks the open sequence, builds result records
// depends on u8d_pkg

module u8d_front import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t in_word_i,
  output logic     rec_push_o,
  output rec_t     rec_o
);

  logic [2:0]  left_q, left_d;
  logic [15:0] part_q, part_d;
  logic        wide_q, wide_d;

  logic [3:0]  n_lead;
  logic        lead_res;
  out_word_t   lead_word;
  logic        lead_open;
  logic [2:0]  lead_left;
  logic [15:0] lead_part;
  logic        lead_wide;

  logic [1:0]  n_res;
  out_word_t   r0, r1;
  logic [7:0]  b;
  logic [2:0]  dec_left;

  assign b        = in_word_i.in_byte;
  assign n_lead   = leading_ones(b);
  assign dec_left = left_q - 3'd1;

  // lead byte classification
  always_comb begin
    lead_res  = 1'b0;
    lead_word = mk_res(16'd0, ST_OK);
    lead_open = 1'b0;
    lead_left = 3'd0;
    lead_part = 16'd0;
    lead_wide = 1'b0;
    if (n_lead == 4'd0) begin
      lead_res  = 1'b1;
      lead_word = mk_res({8'd0, b}, ST_OK);
    end else if (n_lead == 4'd1 || n_lead > 4'(MaxSeqLen)) begin
      lead_res  = 1'b1;
      lead_word = mk_res(16'd0, ST_BAD_LEAD);
    end else begin
      lead_open = 1'b1;
      lead_left = 3'(n_lead - 4'd1);
      if (n_lead == 4'd2) begin
        lead_part = {11'd0, b[4:0]};
      end else if (n_lead == 4'd3) begin
        lead_part = {12'd0, b[3:0]};
      end else begin
        lead_wide = 1'b1;
      end
    end
  end

  always_comb begin
    left_d = left_q;
    part_d = part_q;
    wide_d = wide_q;
    n_res  = 2'd0;
    r0     = mk_res(16'd0, ST_OK);
    r1     = mk_res(16'd0, ST_OK);
    if (accept_i) begin
      if (in_word_i.flush) begin
        if (left_q != 3'd0) begin
          n_res = 2'd1;
          r0    = mk_res(16'd0, ST_TRUNC);
        end
        left_d = 3'd0;
        part_d = 16'd0;
        wide_d = 1'b0;
      end else if (left_q != 3'd0) begin
        if ((b & 8'hC0) == ContMark) begin
          left_d = dec_left;
          if (!wide_q) part_d = {part_q[9:0], b[5:0]};
          if (dec_left == 3'd0) begin
            n_res  = 2'd1;
            r0     = wide_q ? mk_res(16'd0, ST_WIDE) : mk_res({part_q[9:0], b[5:0]}, ST_OK);
            left_d = 3'd0;
            part_d = 16'd0;
            wide_d = 1'b0;
          end
        end else begin
          // broken sequence, then the byte restarts as a lead
          r0     = mk_res(16'd0, ST_TRUNC);
          r1     = lead_word;
          n_res  = lead_res ? 2'd2 : 2'd1;
          left_d = lead_left;
          part_d = lead_part;
          wide_d = lead_wide;
        end
      end else begin
        r0     = lead_word;
        n_res  = lead_res ? 2'd1 : 2'd0;
        left_d = lead_left;
        part_d = lead_part;
        wide_d = lead_wide;
      end
    end
    if (!lead_open && !(accept_i && !in_word_i.flush && left_q == 3'd0)) begin
      // nothing extra; state already set above
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
      part_q <= 16'd0;
      wide_q <= 1'b0;
    end else begin
      left_q <= left_d;
      part_q <= part_d;
      wide_q <= wide_d;
    end
  end

  assign rec_push_o = accept_i && (n_res != 2'd0);
  assign rec_o.two  = (n_res == 2'd2);
  assign rec_o.r0   = r0;
  assign rec_o.r1   = r1;

endmodule

### src/u8d_queue.sv
`timescale 1ns / 1ps
// u8d_queue: short record queue between front and back end
// depends on u8d_pkg

module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  rec_t    rec_i,
  input  logic    deq_i,
  output logic    full_o,
  output q_head_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rec_t              mem_q [Depth];
  logic [AddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = deq_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
    if (do_pop)  rd_d = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o.avail = (cnt_q != '0);
  assign head_o.head  = mem_q[rd_q];

endmodule

### src/u8d_back.sv
`timescale 1ns / 1ps
// u8d_back: hands out the results of the head record one word at a time
// depends on u8d_pkg

module u8d_back import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  input  logic      pop_i,
  output logic      deq_o,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic sel_q, sel_d;
  logic take;

  assign empty_o    = !head_i.avail;
  assign take       = pop_i && head_i.avail;
  assign out_word_o = sel_q ? head_i.head.r1 : head_i.head.r0;

  always_comb begin
    sel_d = sel_q;
    deq_o = 1'b0;
    if (take) begin
      if (!sel_q && head_i.head.two) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        deq_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule
